// ----- rtl/cbs_pkg.sv -----
package cbs_pkg;

  localparam int PIX_W     = 16;
  localparam int COL_OUT_W = 11;
  localparam int ROW_OUT_W = 12;
  localparam int IMG_W_W   = 12;
  localparam int CFG_W     = 16;

  // nine pixels plus the rounding offset
  localparam int SUM_W = PIX_W + 4;

  // floor(x / 9) == (x * RECIP9) >> DIV_SHIFT for every x below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + 4;
  localparam int RECIP_W   = DIV_SHIFT - 3;
  localparam logic [RECIP_W-1:0] RECIP9 =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam logic [SUM_W-1:0] ROUND_OFS = SUM_W'(4);

  localparam logic [0:0] REG_IMAGE_WIDTH      = 1'd0;
  localparam logic [0:0] REG_SMOOTH_THRESHOLD = 1'd1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 12'd480;
  localparam logic [PIX_W-1:0]   THRESHOLD_RST   = 16'd49152;

  typedef struct packed {
    logic                 emit;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
  } cbs_tag_t;

  typedef struct packed {
    logic                 emit;
    logic                 smooth;
    logic [PIX_W-1:0]     centre;
    logic [SUM_W-1:0]     sum;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
  } cbs_win_t;

endpackage

// ----- rtl/conditional_box_smoother_top.sv -----
// conditional 3x3 box smoother
//
// s_tdata carries raster-order pixels, s_tuser flags the first pixel of a
// frame. configuration is a plain write port (cfg_we, cfg_index, cfg_data):
// index 0 sets the row width in pixels, index 1 the smoothing threshold.
// write it only while no word is in flight.
//
// for every pixel at row >= 2 and column >= 2 one word leaves on m_tdata for
// the pixel one row up and one column left: the rounded 3x3 mean when that
// centre pixel is at or above the threshold (m_tuser high), else the centre
// unchanged. border pixels produce nothing.
//
// throughput is one pixel per clock while the receiver keeps up. an accepted
// pixel is registered in the window stage, its sum in the mean stage, and the
// divide by nine lands in the output register that drives m_tvalid.
// when the receiver stalls, the output register and the two stages behind it
// keep filling; s_tready drops only once all of them hold a word.
// reset empties the pipeline and restarts the row and column counters; line
// buffer contents are not cleared, so the stream should open with a frame
// start.
module conditional_box_smoother_top import cbs_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [15:0] pixel_in
  input  logic             s_tuser,   // [0] frame_start
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [39:0]      m_tdata,   // [15:0] pixel_out, [26:16] out_column,
                                      // [38:27] out_row, [39] zero
  output logic             m_tuser,   // [0] was_smoothed
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [IMG_W_W-1:0]   image_width;
  logic [PIX_W-1:0]     smooth_threshold;
  logic                 accept;
  logic                 take;
  logic                 b_valid;
  logic [CW-1:0]        rd_col;
  cbs_tag_t             tag;
  cbs_win_t             win;
  logic [PIX_W-1:0]     pixel_out;
  logic [COL_OUT_W-1:0] out_column;
  logic [ROW_OUT_W-1:0] out_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= IMAGE_WIDTH_RST;
      smooth_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:      image_width      <= cfg_data[IMG_W_W-1:0];
        REG_SMOOTH_THRESHOLD: smooth_threshold <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !b_valid || take;
  assign accept   = s_tvalid && s_tready;

  cbs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_tuser),
    .image_width (image_width),
    .rd_col      (rd_col),
    .tag         (tag)
  );

  cbs_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .take      (take),
    .pixel_in  (s_tdata[PIX_W-1:0]),
    .rd_col    (rd_col),
    .tag_in    (tag),
    .threshold (smooth_threshold),
    .b_valid   (b_valid),
    .win       (win)
  );

  cbs_mean u_mean (
    .clk          (clk),
    .rst          (rst),
    .win          (win),
    .out_ready    (m_tready),
    .take         (take),
    .out_valid    (m_tvalid),
    .pixel_out    (pixel_out),
    .was_smoothed (m_tuser),
    .out_column   (out_column),
    .out_row      (out_row)
  );

  assign m_tdata = {1'b0, out_row, out_column, pixel_out};

`ifndef SYNTH
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");
`endif

endmodule

// ----- rtl/cbs_ram.sv -----
module cbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/cbs_front.sv -----
module cbs_front import cbs_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               frame_start,
  input  logic [IMG_W_W-1:0] image_width,
  output logic [CW-1:0]      rd_col,
  output cbs_tag_t           tag
);

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] last_col;
  logic [RW-1:0] row;

  // width clamped to 3..MAX_WIDTH, kept as the index of the last column
  always_comb begin
    if (image_width < IMG_W_W'(3)) begin
      last_col = CW'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(image_width - IMG_W_W'(1));
    end
  end

  assign rd_col = frame_start ? '0 : column_count;
  assign row    = frame_start ? '0 : row_count;

  assign tag.emit   = (row >= RW'(2)) && (rd_col >= CW'(2));
  assign tag.column = COL_OUT_W'(rd_col - CW'(1));
  assign tag.row    = ROW_OUT_W'(row - RW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (rd_col >= last_col) begin
        column_count <= '0;
        // row count sticks at the last row
        if (row < RW'(MAX_HEIGHT - 1)) begin
          row_count <= row + RW'(1);
        end else begin
          row_count <= row;
        end
      end else begin
        column_count <= rd_col + CW'(1);
        row_count    <= row;
      end
    end
  end

`ifndef SYNTH
  a_row_sat: assert property (@(posedge clk) disable iff (rst)
    accept && !frame_start && row_count == RW'(MAX_HEIGHT - 1)
    |=> row_count == RW'(MAX_HEIGHT - 1))
    else $error("row count left saturation");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> row_count == '0 && column_count == CW'(1))
    else $error("frame start did not restart counters");
`endif

endmodule

// ----- rtl/cbs_window.sv -----
module cbs_window import cbs_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             take,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic [CW-1:0]    rd_col,
  input  cbs_tag_t         tag_in,
  input  logic [PIX_W-1:0] threshold,
  output logic             b_valid,
  output cbs_win_t         win
);

  logic [PIX_W-1:0] b_pix;
  logic [CW-1:0]    b_col;
  cbs_tag_t         b_tag;

  logic [PIX_W-1:0] ram_top;
  logic [PIX_W-1:0] ram_mid;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  logic             wr_en;

  // last line buffer write, for a read that raced it to the same column
  logic             fwd_valid;
  logic [CW-1:0]    fwd_col;
  logic [PIX_W-1:0] fwd_top;
  logic [PIX_W-1:0] fwd_mid;
  logic             fwd_hit;

  logic [PIX_W-1:0] wr0, wr1, wr2, wr3, wr4, wr5;

  assign wr_en = b_valid && take;

  cbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b_col),
    .wr_data (mid),
    .rd_en   (accept),
    .rd_addr (rd_col),
    .rd_data (ram_top)
  );

  cbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b_col),
    .wr_data (b_pix),
    .rd_en   (accept),
    .rd_addr (rd_col),
    .rd_data (ram_mid)
  );

  assign fwd_hit = fwd_valid && (fwd_col == b_col);
  assign top     = fwd_hit ? fwd_top : ram_top;
  assign mid     = fwd_hit ? fwd_mid : ram_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      wr0 <= '0;
      wr1 <= '0;
      wr2 <= '0;
      wr3 <= '0;
      wr4 <= '0;
      wr5 <= '0;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (take) begin
        b_valid <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid <= 1'b1;
        wr3 <= wr0;
        wr4 <= wr1;
        wr5 <= wr2;
        wr0 <= top;
        wr1 <= mid;
        wr2 <= b_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix <= pixel_in;
      b_col <= rd_col;
      b_tag <= tag_in;
    end
    if (wr_en) begin
      fwd_col <= b_col;
      fwd_top <= mid;
      fwd_mid <= b_pix;
    end
  end

  assign win.emit   = b_valid && b_tag.emit;
  assign win.centre = wr1;
  assign win.smooth = wr1 >= threshold;
  assign win.sum    = SUM_W'(wr0) + SUM_W'(wr1) + SUM_W'(wr2)
                    + SUM_W'(wr3) + SUM_W'(wr4) + SUM_W'(wr5)
                    + SUM_W'(top) + SUM_W'(mid) + SUM_W'(b_pix) + ROUND_OFS;
  assign win.column = b_tag.column;
  assign win.row    = b_tag.row;

endmodule

// ----- rtl/cbs_mean.sv -----
module cbs_mean import cbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cbs_win_t             win,
  input  logic                 out_ready,
  output logic                 take,
  output logic                 out_valid,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 was_smoothed,
  output logic [COL_OUT_W-1:0] out_column,
  output logic [ROW_OUT_W-1:0] out_row
);

  logic              c_valid;
  cbs_win_t          c_win;
  logic              en_out;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  mean;

  assign en_out = !out_valid || out_ready;
  assign take   = !c_valid || en_out;

  // divide by nine through the reciprocal
  assign prod = PROD_W'(c_win.sum) * PROD_W'(RECIP9);
  assign mean = prod[DIV_SHIFT +: PIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        c_valid <= win.emit;
      end
      if (en_out) begin
        out_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && win.emit) begin
      c_win <= win;
    end
    if (en_out && c_valid) begin
      pixel_out    <= c_win.smooth ? mean : c_win.centre;
      was_smoothed <= c_win.smooth;
      out_column   <= c_win.column;
      out_row      <= c_win.row;
    end
  end

`ifndef SYNTH
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    c_valid && !en_out |=> c_valid && $stable(c_win.sum))
    else $error("mean stage lost a word under stall");
`endif

endmodule
